// ===== sv/ptc_pkg.sv =====
// ----------------------------------------------------------------------------
// ptc_pkg: shared types and constants for the pressure/temperature compensator
// Transaction payloads, calibration register file layout, stage bundles and
// the fixed widths of the compensation datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package ptc_pkg;

   // field widths
   localparam int CFG_W   = 16;
   localparam int RAW_W   = 24;
   localparam int TEMP_W  = 19;
   localparam int PRES_W  = 24;
   localparam int IDX_W   = 3;

   // internal datapath widths
   localparam int DT_W    = 25;   // D2 - C5*256
   localparam int DEV_W   = 18;   // TEMP - 20.00 C, first order
   localparam int E_W     = 19;   // TEMP + 15.00 C
   localparam int T2_W    = 18;
   localparam int LIN_W   = 36;   // first-order OFF / SENS
   localparam int COMP_W  = 40;   // corrected OFF / SENS
   localparam int SQ_W    = 35;
   localparam int ESQ_W   = 37;

   // pipeline depth from accept to result strobe
   localparam int LATENCY = 10;

   // calibration constants
   localparam int TEMP_REF   = 2000;   // 20.00 C
   localparam int VCOLD_DEV  = 3500;   // 20.00 C - (-15.00 C)
   localparam int TEMP_MAX   = 262143;
   localparam int TEMP_MIN   = -262144;
   localparam int PRES_MAX   = 8388607;
   localparam int PRES_MIN   = -8388608;

   // register indexes
   typedef enum logic [IDX_W-1:0] {
      CSR_C1 = 3'd0,
      CSR_C2 = 3'd1,
      CSR_C3 = 3'd2,
      CSR_C4 = 3'd3,
      CSR_C5 = 3'd4,
      CSR_C6 = 3'd5
   } csr_idx_type;

   typedef struct packed {
      logic [RAW_W-1:0] raw_pressure;
      logic [RAW_W-1:0] raw_temperature;
   } ptc_req_type;

   typedef struct packed {
      logic signed [TEMP_W-1:0] temperature_centi;
      logic signed [PRES_W-1:0] pressure_decimbar;
   } ptc_rsp_type;

   typedef struct packed {
      logic [CFG_W-1:0] pressure_sensitivity;
      logic [CFG_W-1:0] pressure_offset;
      logic [CFG_W-1:0] sens_temp_coeff;
      logic [CFG_W-1:0] offset_temp_coeff;
      logic [CFG_W-1:0] reference_temperature;
      logic [CFG_W-1:0] temp_coeff_of_temp;
   } ptc_cfg_type;

   // first-order terms leaving the front end
   typedef struct packed {
      logic                     valid;
      logic [RAW_W-1:0]         d1;
      logic signed [DEV_W-1:0]  dev;
      logic signed [E_W-1:0]    e;
      logic                     cold;
      logic                     vcold;
      logic signed [LIN_W-1:0]  off_lin;
      logic signed [LIN_W-1:0]  sens_lin;
      logic [T2_W-1:0]          t2;
   } ptc_lin_type;

   // second-order corrected terms
   typedef struct packed {
      logic                     valid;
      logic [RAW_W-1:0]         d1;
      logic signed [TEMP_W-1:0] temp;
      logic signed [COMP_W-1:0] off;
      logic signed [COMP_W-1:0] sens;
   } ptc_comp_type;

endpackage

`default_nettype wire

// ===== sv/ptc_csr.sv =====
// ----------------------------------------------------------------------------
// ptc_csr: calibration register file
// Six 16-bit calibration words, written through a plain write port.
// ----------------------------------------------------------------------------
`default_nettype none

module ptc_csr import ptc_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_wr_en,
   input  logic [IDX_W-1:0]  csr_index,
   input  logic [CFG_W-1:0]  csr_wdata,
   output ptc_cfg_type       cfg
);

   ptc_cfg_type cfg_ff, cfg_in;

   // decode write; unknown indexes are dropped
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         case (csr_idx_type'(csr_index))
            CSR_C1:  cfg_in.pressure_sensitivity  = csr_wdata;
            CSR_C2:  cfg_in.pressure_offset       = csr_wdata;
            CSR_C3:  cfg_in.sens_temp_coeff       = csr_wdata;
            CSR_C4:  cfg_in.offset_temp_coeff     = csr_wdata;
            CSR_C5:  cfg_in.reference_temperature = csr_wdata;
            CSR_C6:  cfg_in.temp_coeff_of_temp    = csr_wdata;
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

// ===== sv/ptc_front.sv =====
// ----------------------------------------------------------------------------
// ptc_front: first-order compensation, pipeline stages 1 to 3
// dT, the dT products, first-order OFF/SENS, band flags and the T2 term.
// ----------------------------------------------------------------------------
`default_nettype none

module ptc_front import ptc_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         acc,
   input  ptc_req_type  req,
   input  ptc_cfg_type  cfg,
   output ptc_lin_type  lin
);

   // stage 1: temperature difference
   logic                    s1_valid_ff;
   logic [RAW_W-1:0]        s1_d1_ff;
   logic signed [DT_W-1:0]  s1_dt_ff, s1_dt_in;

   assign s1_dt_in = $signed({1'b0, req.raw_temperature})
                   - $signed({1'b0, cfg.reference_temperature, 8'd0});

   // stage 2: products of dT
   logic                    s2_valid_ff;
   logic [RAW_W-1:0]        s2_d1_ff;
   logic signed [CFG_W:0]   c6_s, c4_s, c3_s;
   logic signed [41:0]      s2_prod_t_in, s2_prod_off_in, s2_prod_sens_in;
   logic signed [41:0]      s2_prod_t_ff, s2_prod_off_ff, s2_prod_sens_ff;
   logic signed [49:0]      s2_dsq_in;
   logic [48:0]             s2_dsq_ff;

   assign c6_s = $signed({1'b0, cfg.temp_coeff_of_temp});
   assign c4_s = $signed({1'b0, cfg.offset_temp_coeff});
   assign c3_s = $signed({1'b0, cfg.sens_temp_coeff});

   assign s2_prod_t_in    = s1_dt_ff * c6_s;
   assign s2_prod_off_in  = s1_dt_ff * c4_s;
   assign s2_prod_sens_in = s1_dt_ff * c3_s;
   assign s2_dsq_in       = s1_dt_ff * s1_dt_ff;

   // stage 3: first-order terms and T2
   ptc_lin_type             s3_ff, s3_in;
   logic signed [DEV_W-1:0] dev;
   logic [15:0]             dsq_hi;
   logic [T2_W-1:0]         t2_cold;
   logic [51:0]             dsq7;
   logic [T2_W-1:0]         t2_warm;

   always_comb begin
      dev     = s2_prod_t_ff[40:23];
      dsq_hi  = s2_dsq_ff[48:33];
      t2_cold = {1'b0, dsq_hi, 1'b0} + {2'b00, dsq_hi};
      dsq7    = {s2_dsq_ff, 3'b000} - {3'b000, s2_dsq_ff};
      t2_warm = {3'b000, dsq7[51:37]};

      s3_in.valid    = s2_valid_ff;
      s3_in.d1       = s2_d1_ff;
      s3_in.dev      = dev;
      s3_in.e        = $signed({dev[DEV_W-1], dev}) + E_W'(VCOLD_DEV);
      s3_in.cold     = dev[DEV_W-1];
      s3_in.vcold    = (dev < -DEV_W'(VCOLD_DEV));
      s3_in.off_lin  = $signed({4'd0, cfg.pressure_offset, 16'd0})
                     + $signed({s2_prod_off_ff[41], s2_prod_off_ff[41:7]});
      s3_in.sens_lin = $signed({5'd0, cfg.pressure_sensitivity, 15'd0})
                     + $signed({{2{s2_prod_sens_ff[41]}}, s2_prod_sens_ff[41:8]});
      s3_in.t2       = dev[DEV_W-1] ? t2_cold : t2_warm;
   end

   // valid bits are reset, payload runs free
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_ff.valid <= 1'b0;
      end else begin
         s1_valid_ff <= acc;
         s2_valid_ff <= s1_valid_ff;
         s3_ff.valid <= s3_in.valid;
      end
      s1_d1_ff        <= req.raw_pressure;
      s1_dt_ff        <= s1_dt_in;
      s2_d1_ff        <= s1_d1_ff;
      s2_prod_t_ff    <= s2_prod_t_in;
      s2_prod_off_ff  <= s2_prod_off_in;
      s2_prod_sens_ff <= s2_prod_sens_in;
      s2_dsq_ff       <= s2_dsq_in[48:0];
      s3_ff.d1        <= s3_in.d1;
      s3_ff.dev       <= s3_in.dev;
      s3_ff.e         <= s3_in.e;
      s3_ff.cold      <= s3_in.cold;
      s3_ff.vcold     <= s3_in.vcold;
      s3_ff.off_lin   <= s3_in.off_lin;
      s3_ff.sens_lin  <= s3_in.sens_lin;
      s3_ff.t2        <= s3_in.t2;
   end

   assign lin = s3_ff;

endmodule

`default_nettype wire

// ===== sv/ptc_corr.sv =====
// ----------------------------------------------------------------------------
// ptc_corr: second-order correction, pipeline stages 4 to 6
// Squares of the temperature deviation, final temperature with saturation,
// OFF2/SENS2 by band and the corrected OFF/SENS.
// ----------------------------------------------------------------------------
`default_nettype none

module ptc_corr import ptc_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  ptc_lin_type   lin,
   output ptc_comp_type  comp
);

   // stage 4: squares and final temperature
   logic                     s4_valid_ff;
   logic [RAW_W-1:0]         s4_d1_ff;
   logic                     s4_cold_ff, s4_vcold_ff;
   logic signed [LIN_W-1:0]  s4_off_lin_ff, s4_sens_lin_ff;
   logic signed [2*DEV_W-1:0] s4_sq_in;
   logic signed [2*E_W-1:0]  s4_esq_in;
   logic [SQ_W-1:0]          s4_sq_ff;
   logic [ESQ_W-1:0]         s4_esq_ff;
   logic signed [TEMP_W:0]   tsum;
   logic signed [TEMP_W-1:0] s4_temp_ff, s4_temp_in;

   assign s4_sq_in  = lin.dev * lin.dev;
   assign s4_esq_in = lin.e * lin.e;

   always_comb begin
      tsum = $signed({{2{lin.dev[DEV_W-1]}}, lin.dev}) + (TEMP_W+1)'(TEMP_REF)
           - $signed({2'b00, lin.t2});
      if (tsum > TEMP_MAX) begin
         s4_temp_in = TEMP_W'(TEMP_MAX);
      end else if (tsum < TEMP_MIN) begin
         s4_temp_in = TEMP_W'(TEMP_MIN);
      end else begin
         s4_temp_in = tsum[TEMP_W-1:0];
      end
   end

   // stage 5: OFF2 and SENS2 by band
   logic                     s5_valid_ff;
   logic [RAW_W-1:0]         s5_d1_ff;
   logic signed [TEMP_W-1:0] s5_temp_ff;
   logic signed [LIN_W-1:0]  s5_off_lin_ff, s5_sens_lin_ff;
   logic [COMP_W-1:0]        sq40, esq40, sq3, sq5, s5_off2_in, s5_sens2_in;
   logic [COMP_W-1:0]        s5_off2_ff, s5_sens2_ff;

   always_comb begin
      sq40  = {{(COMP_W-SQ_W){1'b0}}, s4_sq_ff};
      esq40 = {{(COMP_W-ESQ_W){1'b0}}, s4_esq_ff};
      sq3   = (sq40 << 1) + sq40;
      sq5   = (sq40 << 2) + sq40;
      if (s4_cold_ff) begin
         s5_off2_in  = (sq3 >> 1) + (s4_vcold_ff ? ((esq40 << 3) - esq40) : '0);
         s5_sens2_in = (sq5 >> 3) + (s4_vcold_ff ? (esq40 << 2) : '0);
      end else begin
         s5_off2_in  = sq40 >> 4;
         s5_sens2_in = '0;
      end
   end

   // stage 6: corrected OFF and SENS
   ptc_comp_type             s6_ff, s6_in;

   always_comb begin
      s6_in.valid = s5_valid_ff;
      s6_in.d1    = s5_d1_ff;
      s6_in.temp  = s5_temp_ff;
      s6_in.off   = $signed({{(COMP_W-LIN_W){s5_off_lin_ff[LIN_W-1]}}, s5_off_lin_ff})
                  - $signed(s5_off2_ff);
      s6_in.sens  = $signed({{(COMP_W-LIN_W){s5_sens_lin_ff[LIN_W-1]}}, s5_sens_lin_ff})
                  - $signed(s5_sens2_ff);
   end

   // valid bits are reset, payload runs free
   always_ff @(posedge clock) begin
      if (reset) begin
         s4_valid_ff <= 1'b0;
         s5_valid_ff <= 1'b0;
         s6_ff.valid <= 1'b0;
      end else begin
         s4_valid_ff <= lin.valid;
         s5_valid_ff <= s4_valid_ff;
         s6_ff.valid <= s6_in.valid;
      end
      s4_d1_ff       <= lin.d1;
      s4_cold_ff     <= lin.cold;
      s4_vcold_ff    <= lin.vcold;
      s4_off_lin_ff  <= lin.off_lin;
      s4_sens_lin_ff <= lin.sens_lin;
      s4_sq_ff       <= s4_sq_in[SQ_W-1:0];
      s4_esq_ff      <= s4_esq_in[ESQ_W-1:0];
      s4_temp_ff     <= s4_temp_in;
      s5_d1_ff       <= s4_d1_ff;
      s5_temp_ff     <= s4_temp_ff;
      s5_off_lin_ff  <= s4_off_lin_ff;
      s5_sens_lin_ff <= s4_sens_lin_ff;
      s5_off2_ff     <= s5_off2_in;
      s5_sens2_ff    <= s5_sens2_in;
      s6_ff.d1       <= s6_in.d1;
      s6_ff.temp     <= s6_in.temp;
      s6_ff.off      <= s6_in.off;
      s6_ff.sens     <= s6_in.sens;
   end

   assign comp = s6_ff;

endmodule

`default_nettype wire

// ===== sv/ptc_pres.sv =====
// ----------------------------------------------------------------------------
// ptc_pres: pressure evaluation, pipeline stages 7 to 10
// SENS*D1 as two partial products, recombination, offset removal, final
// scaling and saturation into the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module ptc_pres import ptc_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  ptc_comp_type  comp,
   output logic          rsp_valid,
   output ptc_rsp_type   rsp_data
);

   // stage 7: partial products of SENS*D1 (SENS split at bit 20)
   logic                     s7_valid_ff;
   logic signed [TEMP_W-1:0] s7_temp_ff;
   logic signed [COMP_W-1:0] s7_off_ff;
   logic signed [19:0]       sens_hi;
   logic [19:0]              sens_lo;
   logic signed [RAW_W:0]    d1_s;
   logic signed [44:0]       s7_pp_hi_in, s7_pp_hi_ff;
   logic [43:0]              s7_pp_lo_in, s7_pp_lo_ff;

   assign sens_hi     = comp.sens[COMP_W-1:20];
   assign sens_lo     = comp.sens[19:0];
   assign d1_s        = $signed({1'b0, comp.d1});
   assign s7_pp_hi_in = sens_hi * d1_s;
   assign s7_pp_lo_in = sens_lo * comp.d1;

   // stage 8: full product, scaled by 2^-21
   logic                     s8_valid_ff;
   logic signed [TEMP_W-1:0] s8_temp_ff;
   logic signed [COMP_W-1:0] s8_off_ff;
   logic signed [63:0]       prod;
   logic signed [42:0]       s8_scaled_ff;

   assign prod = $signed({s7_pp_hi_ff[43:0], 20'd0}) + $signed({20'd0, s7_pp_lo_ff});

   // stage 9: remove offset
   logic                     s9_valid_ff;
   logic signed [TEMP_W-1:0] s9_temp_ff;
   logic signed [43:0]       s9_q_in, s9_q_ff;

   assign s9_q_in = $signed({s8_scaled_ff[42], s8_scaled_ff})
                  - $signed({{4{s8_off_ff[COMP_W-1]}}, s8_off_ff});

   // stage 10: scale by 2^-15 and saturate
   logic                     s10_valid_ff;
   ptc_rsp_type              s10_rsp_ff, s10_rsp_in;
   logic signed [28:0]       pq;

   always_comb begin
      pq = s9_q_ff[43:15];
      s10_rsp_in.temperature_centi = s9_temp_ff;
      if (pq > PRES_MAX) begin
         s10_rsp_in.pressure_decimbar = PRES_W'(PRES_MAX);
      end else if (pq < PRES_MIN) begin
         s10_rsp_in.pressure_decimbar = PRES_W'(PRES_MIN);
      end else begin
         s10_rsp_in.pressure_decimbar = pq[PRES_W-1:0];
      end
   end

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         s7_valid_ff  <= 1'b0;
         s8_valid_ff  <= 1'b0;
         s9_valid_ff  <= 1'b0;
         s10_valid_ff <= 1'b0;
      end else begin
         s7_valid_ff  <= comp.valid;
         s8_valid_ff  <= s7_valid_ff;
         s9_valid_ff  <= s8_valid_ff;
         s10_valid_ff <= s9_valid_ff;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      s7_temp_ff   <= comp.temp;
      s7_off_ff    <= comp.off;
      s7_pp_hi_ff  <= s7_pp_hi_in;
      s7_pp_lo_ff  <= s7_pp_lo_in;
      s8_temp_ff   <= s7_temp_ff;
      s8_off_ff    <= s7_off_ff;
      s8_scaled_ff <= prod[63:21];
      s9_temp_ff   <= s8_temp_ff;
      s9_q_ff      <= s9_q_in;
      s10_rsp_ff   <= s10_rsp_in;
   end

   assign rsp_valid = s10_valid_ff;
   assign rsp_data  = s10_rsp_ff;

endmodule

`default_nettype wire

// ===== sv/pressure_temperature_compensation_top.sv =====
// ----------------------------------------------------------------------------
// pressure_temperature_compensation_top: second-order sensor compensation
// The result strobe comes from the last register of the pipeline.
// Throughput: one transaction per cycle; the 10-stage datapath never stalls.
// busy is high only while reset is held; results cannot be held off.
// Reset clears the calibration words and every pipeline valid bit.
// ----------------------------------------------------------------------------
`default_nettype none

module pressure_temperature_compensation_top import ptc_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   // request
   input  logic              start,
   output logic              busy,
   input  ptc_req_type       req_data,
   // response
   output logic              rsp_valid,
   output ptc_rsp_type       rsp_data,
   // calibration registers
   input  logic              csr_wr_en,
   input  logic [IDX_W-1:0]  csr_index,
   input  logic [CFG_W-1:0]  csr_wdata
);

   ptc_cfg_type  cfg;
   ptc_lin_type  lin;
   ptc_comp_type comp;
   logic         acc;

   assign busy = reset;
   assign acc  = start & ~busy;

   ptc_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   ptc_front u_front (
      .clock (clock),
      .reset (reset),
      .acc   (acc),
      .req   (req_data),
      .cfg   (cfg),
      .lin   (lin)
   );

   ptc_corr u_corr (
      .clock (clock),
      .reset (reset),
      .lin   (lin),
      .comp  (comp)
   );

   ptc_pres u_pres (
      .clock     (clock),
      .reset     (reset),
      .comp      (comp),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire

// ===== sv/ptc_checker.sv =====
// ----------------------------------------------------------------------------
// ptc_checker: port-level checks for the compensation block
// Result strobes line up one for one with accepted transactions.
// ----------------------------------------------------------------------------
`default_nettype none

module ptc_checker import ptc_pkg::*; (
   input logic clock,
   input logic reset,
   input logic start,
   input logic busy,
   input logic rsp_valid
);

   // every strobe comes from an earlier accepted transaction
   a_rsp_from_txn: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, LATENCY))
      else $error("result strobe without a matching transaction");

   // every accepted transaction produces its strobe
   a_txn_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##LATENCY rsp_valid)
      else $error("accepted transaction lost");

   // reset flushes the pipeline
   a_reset_flush: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result strobe right after reset");

   // nothing is taken while reset is held
   a_no_txn_in_reset: assert property (@(posedge clock)
      reset |-> !(start && !busy))
      else $error("transaction accepted during reset");

endmodule

bind pressure_temperature_compensation_top ptc_checker u_ptc_checker (.*);

`default_nettype wire

// ===== sim/compensation_checker.sv =====
// ----------------------------------------------------------------------------
// compensation_checker: scoreboard for the pressure/temperature compensator
// Mirrors the calibration words from the write port, predicts the compensated
// reading for every accepted transaction and compares each result strobe, in
// order, against the oldest prediction.
// ----------------------------------------------------------------------------
`default_nettype none

module compensation_checker import ptc_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic        busy,
   input  ptc_req_type req_data,
   input  logic        rsp_valid,
   input  ptc_rsp_type rsp_data,
   input  logic        csr_wr_en,
   input  logic [IDX_W-1:0] csr_index,
   input  logic [CFG_W-1:0] csr_wdata,
   output int          error_count,
   output int          readings_in_flight
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int REPORT_LIMIT = 10;

   ptc_cfg_type cal = '0;
   ptc_rsp_type expected_readings[$];
   ptc_rsp_type want;

   initial begin
      error_count = 0;
      readings_in_flight = 0;
   end

   // Second-order compensation at full 64-bit width; >>> on longint floors.
   function automatic ptc_rsp_type compensate(input ptc_cfg_type c, input ptc_req_type s);
      longint d1, d2, c1, c2, c3, c4, c5, c6;
      longint dt, temp, off, sens, t2, off2, sens2, dsq, dev, sq, ecold, pres;
      ptc_rsp_type r;
      d1 = longint'(s.raw_pressure);
      d2 = longint'(s.raw_temperature);
      c1 = longint'(c.pressure_sensitivity);
      c2 = longint'(c.pressure_offset);
      c3 = longint'(c.sens_temp_coeff);
      c4 = longint'(c.offset_temp_coeff);
      c5 = longint'(c.reference_temperature);
      c6 = longint'(c.temp_coeff_of_temp);

      // first-order terms
      dt   = d2 - c5 * 256;
      temp = ((dt * c6) >>> 23) + TEMP_REF;
      off  = (c2 <<< 16) + ((c4 * dt) >>> 7);
      sens = (c1 <<< 15) + ((c3 * dt) >>> 8);

      // band selection uses the first-order temperature
      dsq = dt * dt;
      dev = temp - TEMP_REF;
      sq  = dev * dev;
      if (temp < TEMP_REF) begin
         t2    = 3 * (dsq >>> 33);
         off2  = (3 * sq) >>> 1;
         sens2 = (5 * sq) >>> 3;
         if (temp < TEMP_REF - VCOLD_DEV) begin
            ecold = temp + VCOLD_DEV - TEMP_REF;
            off2  = off2 + 7 * (ecold * ecold);
            sens2 = sens2 + 4 * (ecold * ecold);
         end
      end else begin
         t2    = (7 * dsq) >>> 37;
         off2  = sq >>> 4;
         sens2 = 0;
      end

      temp = temp - t2;
      off  = off - off2;
      sens = sens - sens2;
      pres = (((sens * d1) >>> 21) - off) >>> 15;

      // saturate to the output fields
      if (temp < TEMP_MIN) temp = TEMP_MIN;
      if (temp > TEMP_MAX) temp = TEMP_MAX;
      if (pres < PRES_MIN) pres = PRES_MIN;
      if (pres > PRES_MAX) pres = PRES_MAX;

      r.temperature_centi = temp[TEMP_W-1:0];
      r.pressure_decimbar = pres[PRES_W-1:0];
      return r;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         cal = '0;
         expected_readings.delete();
      end else begin
         // result side first: a result never belongs to the transaction taken at this edge
         if (rsp_valid) begin
            if (expected_readings.size() == 0) begin
               error_count++;
               if (error_count <= REPORT_LIMIT)
                  $display("%0t: unexpected result temp=%0d pres=%0d", $time,
                           rsp_data.temperature_centi, rsp_data.pressure_decimbar);
            end else begin
               want = expected_readings.pop_front();
               if (rsp_data.temperature_centi !== want.temperature_centi ||
                   rsp_data.pressure_decimbar !== want.pressure_decimbar) begin
                  error_count++;
                  if (error_count <= REPORT_LIMIT)
                     $display("%0t: mismatch temp exp=%0d got=%0d, pres exp=%0d got=%0d",
                              $time, want.temperature_centi, rsp_data.temperature_centi,
                              want.pressure_decimbar, rsp_data.pressure_decimbar);
               end
            end
         end

         // request side
         if (start && !busy)
            expected_readings.push_back(compensate(cal, req_data));

         // calibration writes; unmapped indexes are dropped
         if (csr_wr_en) begin
            case (csr_index)
               CSR_C1:  cal.pressure_sensitivity  = csr_wdata;
               CSR_C2:  cal.pressure_offset       = csr_wdata;
               CSR_C3:  cal.sens_temp_coeff       = csr_wdata;
               CSR_C4:  cal.offset_temp_coeff     = csr_wdata;
               CSR_C5:  cal.reference_temperature = csr_wdata;
               CSR_C6:  cal.temp_coeff_of_temp    = csr_wdata;
               default: ;
            endcase
         end
      end
      readings_in_flight = expected_readings.size();
   end

endmodule

`default_nettype wire

// ===== sim/pressure_temperature_compensation_top_tb.sv =====
// ----------------------------------------------------------------------------
// pressure_temperature_compensation_top_tb: compensator testbench
// Runs the block through several calibration sets (typical, all ones, all
// zeros, random mixes of extremes and random words) with directed band-edge readings and
// bursty random traffic; the checker predicts and scores every result.
// ----------------------------------------------------------------------------
`default_nettype none

module pressure_temperature_compensation_top_tb;
   import ptc_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam longint RAW_MAX     = (longint'(1) <<< RAW_W) - 1;
   localparam longint TYPICAL_D1  = 4311550;
   localparam int     PHASES      = 8;
   localparam int     PHASE_ITEMS = 125;

   // indexes past the last calibration word
   localparam logic [IDX_W-1:0] CSR_UNMAPPED_LO = 3'd6;
   localparam logic [IDX_W-1:0] CSR_UNMAPPED_HI = 3'd7;

   localparam ptc_cfg_type TYPICAL_CAL = '{
      pressure_sensitivity:  16'd46372,
      pressure_offset:       16'd43981,
      sens_temp_coeff:       16'd29059,
      offset_temp_coeff:     16'd27842,
      reference_temperature: 16'd31553,
      temp_coeff_of_temp:    16'd28165
   };

   logic              clock     = 1'b0;
   logic              reset     = 1'b1;
   logic              start     = 1'b0;
   logic              busy;
   ptc_req_type       req_data  = '0;
   logic              rsp_valid;
   ptc_rsp_type       rsp_data;
   logic              csr_wr_en = 1'b0;
   logic [IDX_W-1:0]  csr_index = CSR_C1;
   logic [CFG_W-1:0]  csr_wdata = '0;
   int                error_count;
   int                readings_in_flight;
   int                burst_left = 0;

   always #5 clock = ~clock;

   pressure_temperature_compensation_top dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   compensation_checker u_checker (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_data           (req_data),
      .rsp_valid          (rsp_valid),
      .rsp_data           (rsp_data),
      .csr_wr_en          (csr_wr_en),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata),
      .error_count        (error_count),
      .readings_in_flight (readings_in_flight)
   );

   function automatic ptc_req_type reading(input longint d1, input longint d2);
      ptc_req_type r;
      if (d2 < 0) d2 = 0;
      if (d2 > RAW_MAX) d2 = RAW_MAX;
      r.raw_pressure    = d1[RAW_W-1:0];
      r.raw_temperature = d2[RAW_W-1:0];
      return r;
   endfunction

   function automatic logic [CFG_W-1:0] random_word();
      case ($urandom_range(0, 3))
         0:       return '0;
         1:       return '1;
         default: return CFG_W'($urandom);
      endcase
   endfunction

   function automatic longint pick_raw_pressure();
      case ($urandom_range(0, 7))
         0:       return 0;
         1:       return RAW_MAX;
         default: return longint'($urandom_range(0, RAW_MAX));
      endcase
   endfunction

   // mostly around the reference code so all three bands get traffic
   function automatic longint pick_raw_temperature(input ptc_cfg_type cal);
      longint centre;
      centre = longint'(cal.reference_temperature) * 256;
      case ($urandom_range(0, 9))
         0:       return 0;
         1:       return RAW_MAX;
         2, 3:    return longint'($urandom_range(0, RAW_MAX));
         4:       return centre + longint'($urandom_range(0, 128)) - 64;
         default: return centre + longint'($urandom_range(0, 1 << 22)) - (1 << 21);
      endcase
   endfunction

   // one transaction; bursts of random length separated by random gaps
   task automatic send_sample(input ptc_req_type smp);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 32);
         gap = ($urandom_range(0, 3) == 0) ? $urandom_range(4, 16) : $urandom_range(0, 3);
         if (gap > 0) begin
            @(negedge clock);
            start <= 1'b0;
            repeat (gap - 1) @(negedge clock);
         end
      end
      burst_left--;
      @(negedge clock);
      start    <= 1'b1;
      req_data <= smp;
      @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   // stop sending and wait for every outstanding result
   task automatic drain_readings();
      @(negedge clock);
      start <= 1'b0;
      wait (readings_in_flight == 0);
   endtask

   task automatic write_register(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
   endtask

   task automatic write_calibration(input ptc_cfg_type cal);
      write_register(CSR_C1, cal.pressure_sensitivity);
      write_register(CSR_C2, cal.pressure_offset);
      write_register(CSR_C3, cal.sens_temp_coeff);
      write_register(CSR_C4, cal.offset_temp_coeff);
      write_register(CSR_C5, cal.reference_temperature);
      write_register(CSR_C6, cal.temp_coeff_of_temp);
      // writes past the last word must not land anywhere
      write_register(CSR_UNMAPPED_LO, CFG_W'($urandom));
      write_register(CSR_UNMAPPED_HI, CFG_W'($urandom));
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   // stimulus
   initial begin
      ptc_cfg_type cal;
      ptc_req_type smp;
      longint      centre;
      longint      cold_edge;
      int          pause_at;

      repeat (5) @(negedge clock);
      reset <= 1'b0;

      for (int phase = 0; phase < PHASES; phase++) begin
         case (phase)
            0:       cal = TYPICAL_CAL;
            1:       cal = '1;
            2:       cal = '0;
            default: begin
               cal.pressure_sensitivity  = random_word();
               cal.pressure_offset       = random_word();
               cal.sens_temp_coeff       = random_word();
               cal.offset_temp_coeff     = random_word();
               cal.reference_temperature = random_word();
               cal.temp_coeff_of_temp    = random_word();
            end
         endcase
         drain_readings();
         write_calibration(cal);

         // directed: field extremes and the band edges under typical calibration
         if (phase == 0) begin
            centre    = longint'(cal.reference_temperature) * 256;
            cold_edge = (longint'(VCOLD_DEV) <<< 23) / longint'(cal.temp_coeff_of_temp);
            send_sample(reading(0, 0));
            send_sample(reading(RAW_MAX, RAW_MAX));
            send_sample(reading(0, RAW_MAX));
            send_sample(reading(RAW_MAX, 0));
            send_sample(reading(TYPICAL_D1, centre));                // exactly 20.00 C
            send_sample(reading(TYPICAL_D1, centre - 1));            // just cold
            send_sample(reading(TYPICAL_D1, centre + 1));
            send_sample(reading(TYPICAL_D1, centre - cold_edge));    // -15.00 C, cold only
            send_sample(reading(TYPICAL_D1, centre - cold_edge - 1)); // very cold
            send_sample(reading(RAW_MAX, centre - cold_edge - 1));
            send_sample(reading(24'hAAAAAA, centre + (1 << 20)));
            send_sample(reading(24'h555555, centre - (1 << 21)));
            send_sample(reading(0, centre));
            send_sample(reading(TYPICAL_D1, centre + 12345));
         end

         // random traffic, with one full drain somewhere in the middle
         pause_at = $urandom_range(0, PHASE_ITEMS - 1);
         for (int i = 0; i < PHASE_ITEMS; i++) begin
            if (i == pause_at)
               drain_readings();
            smp = reading(pick_raw_pressure(), pick_raw_temperature(cal));
            send_sample(smp);
         end
      end

      drain_readings();
      repeat (LATENCY + 4) @(posedge clock);
      if (error_count == 0 && readings_in_flight == 0)
         $display("pressure_temperature_compensation_top test passed");
      else
         $display("pressure_temperature_compensation_top test failed");
      $finish;
   end

   // watchdog
   initial begin
      #2_000_000;
      $display("pressure_temperature_compensation_top test failed");
      $finish;
   end

endmodule

`default_nettype wire
